FILE: src/assert_macros.svh
// Assertion macros shared by the LSTM cell update RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication checked on the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

FILE: src/lcu_pkg.sv
// Types, constants and fixed-point helpers for the LSTM cell update.
package lcu_pkg;

    localparam int CELL_COUNT = 1024;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int POS_W      = 10;
    localparam int Q_W        = 16;
    localparam int PROD_W     = 34;

    typedef logic signed [Q_W-1:0] q_t;

    typedef struct packed {
        logic               valid;
        logic [CELL_AW-1:0] pos;
        logic               first;
        q_t                 g_forget;
        q_t                 g_input;
        q_t                 g_output;
        q_t                 g_cand;
    } gate_t;

    typedef struct packed {
        logic               valid;
        logic [CELL_AW-1:0] pos;
        q_t                 value;
        q_t                 g_output;
    } cell_t;

    function automatic q_t sat16(input logic signed [16:0] v);
        q_t r;
        if (v > 17'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -17'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic q_t gate_add(input q_t x, input q_t h);
        logic signed [16:0] s;
        s = 17'(x) + 17'(h);
        return sat16(s);
    endfunction

    // Piecewise-linear sigmoid on a 17-bit Q5.11 argument.
    function automatic q_t pwl_sigmoid(input logic signed [16:0] a);
        logic signed [17:0] ax;
        logic [17:0]        m;
        logic [12:0]        y;
        logic [12:0]        r;
        ax = 18'(a);
        m  = ax[17] ? 18'(-ax) : 18'(ax);
        if (m >= 18'd10240) begin
            y = 13'd2048;
        end else if (m >= 18'd4864) begin
            y = 13'(m >> 5) + 13'd1728;
        end else if (m >= 18'd2048) begin
            y = 13'(m >> 3) + 13'd1280;
        end else begin
            y = 13'(m >> 2) + 13'd1024;
        end
        r = ax[17] ? 13'd2048 - y : y;
        return q_t'({3'b000, r});
    endfunction

    // tanh(a) = 2*sigmoid(2a) - 1, with 2a kept at full width.
    function automatic q_t pwl_tanh(input q_t a);
        q_t s;
        s = pwl_sigmoid({a, 1'b0});
        return (s <<< 1) - 16'sd2048;
    endfunction

    // Scale by 2^-11, round half up, saturate.
    function automatic q_t rescale(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        logic signed [PROD_W-1:0] r;
        q_t                       o;
        q = p + PROD_W'(1024);
        r = q >>> 11;
        if (r > PROD_W'(32767)) begin
            o = 16'sh7FFF;
        end else if (r < -PROD_W'(32768)) begin
            o = 16'sh8000;
        end else begin
            o = r[15:0];
        end
        return o;
    endfunction

endpackage

FILE: src/lstm_cell_elementwise_update.sv
// Top level of the pointwise LSTM cell update.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready | position, 4 input-side + 4 hidden-side gates
//  m_      | out | m_tvalid/m_tready | hidden_out, cell_out
//
// One transfer per cycle unless the output stalls or an entry hazard holds; items
// pass the gate, product, cell, tanh, product and output registers in turn. The
// cell store is a 1024 x 16 memory with registered read; an item whose position
// matches the item in the gate stage waits, as its previous cell is not yet computed.
// aresetn is synchronous, active low; it clears the valid bits, not the store.
// A stalled output freezes the whole pipeline and drops s_tready.
module lstm_cell_elementwise_update import lcu_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [9:0] position, [25:10] x_forget, [41:26] x_input, [57:42] x_output,
    // [73:58] x_candidate, [89:74] h_forget, [105:90] h_input,
    // [121:106] h_output, [137:122] h_candidate, [143:138] zero
    input  logic [143:0] s_tdata,
    // [0] first_step
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] hidden_out, [31:16] cell_out
    output logic [31:0]  m_tdata
);

    logic  en;
    logic  accept;
    logic  hazard;
    logic  out_valid;
    gate_t gate;
    cell_t cell_stage;
    q_t    hidden_out;
    q_t    cell_out;

    // Advance every stage whenever the output register is free or drained.
    assign en       = !out_valid || m_tready;
    assign s_tready = en && !hazard;
    assign accept   = s_tvalid && s_tready;

    lcu_gate_act u_gate (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .accept      (accept),
        .position    (s_tdata[9:0]),
        .first_step  (s_tuser),
        .x_forget    (s_tdata[25:10]),
        .x_input     (s_tdata[41:26]),
        .x_output    (s_tdata[57:42]),
        .x_candidate (s_tdata[73:58]),
        .h_forget    (s_tdata[89:74]),
        .h_input     (s_tdata[105:90]),
        .h_output    (s_tdata[121:106]),
        .h_candidate (s_tdata[137:122]),
        .gate        (gate)
    );

    lcu_cell_update u_cell (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .rd_pos     (s_tdata[CELL_AW-1:0]),
        .gate       (gate),
        .hazard     (hazard),
        .cell_stage (cell_stage)
    );

    lcu_hidden_out u_hidden (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .cell_stage (cell_stage),
        .out_valid  (out_valid),
        .hidden_out (hidden_out),
        .cell_out   (cell_out)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {cell_out, hidden_out};

    `ASSERT_IMPL(a_hazard_blocks, hazard, !s_tready, "accepted item during entry hazard")

endmodule

FILE: src/lcu_gate_act.sv
// Gate stage: pairwise sums and piecewise-linear activations.
module lcu_gate_act import lcu_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               accept,
    input  logic [POS_W-1:0]   position,
    input  logic               first_step,
    input  q_t                 x_forget,
    input  q_t                 x_input,
    input  q_t                 x_output,
    input  q_t                 x_candidate,
    input  q_t                 h_forget,
    input  q_t                 h_input,
    input  q_t                 h_output,
    input  q_t                 h_candidate,
    output gate_t              gate
);

    gate_t gate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg.valid <= 1'b0;
        end else if (en) begin
            gate_reg.valid <= accept;
        end
        if (en && accept) begin
            gate_reg.pos      <= position[CELL_AW-1:0];
            gate_reg.first    <= first_step;
            gate_reg.g_forget <= pwl_sigmoid(17'(gate_add(x_forget, h_forget)));
            gate_reg.g_input  <= pwl_sigmoid(17'(gate_add(x_input, h_input)));
            gate_reg.g_output <= pwl_sigmoid(17'(gate_add(x_output, h_output)));
            gate_reg.g_cand   <= pwl_tanh(gate_add(x_candidate, h_candidate));
        end
    end

    assign gate = gate_reg;

endmodule

FILE: src/lcu_cell_update.sv
// Cell store, read-modify-write of the cell value with forwarding.
`include "assert_macros.svh"
module lcu_cell_update import lcu_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic [CELL_AW-1:0] rd_pos,
    input  gate_t              gate,
    output logic               hazard,
    output cell_t              cell_stage
);

    q_t                       mem [CELL_COUNT];
    q_t                       rdata_reg;
    logic                     s2_valid_reg;
    logic [CELL_AW-1:0]       s2_pos_reg;
    q_t                       s2_go_reg;
    logic signed [31:0]       s2_p1_reg;
    logic signed [31:0]       s2_p2_reg;
    cell_t                    cell_reg;
    q_t                       prev;
    q_t                       cell_next;
    logic signed [PROD_W-1:0] acc;

    // Hold back an item whose entry is still being computed one stage ahead.
    assign hazard = gate.valid && (gate.pos == rd_pos);

    always_comb begin
        if (gate.first) begin
            prev = '0;
        end else if (cell_reg.valid && (cell_reg.pos == gate.pos)) begin
            prev = cell_reg.value;
        end else begin
            prev = rdata_reg;
        end
    end

    assign acc       = PROD_W'(s2_p1_reg) + PROD_W'(s2_p2_reg);
    assign cell_next = rescale(acc);

    always_ff @(posedge aclk) begin
        if (en) begin
            rdata_reg <= mem[rd_pos];
        end
        if (en && s2_valid_reg) begin
            mem[s2_pos_reg] <= cell_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg   <= 1'b0;
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            s2_valid_reg   <= gate.valid;
            cell_reg.valid <= s2_valid_reg;
        end
        if (en) begin
            s2_pos_reg        <= gate.pos;
            s2_go_reg         <= gate.g_output;
            s2_p1_reg         <= 32'(gate.g_cand) * 32'(gate.g_input);
            s2_p2_reg         <= 32'(prev) * 32'(gate.g_forget);
            cell_reg.pos      <= s2_pos_reg;
            cell_reg.value    <= cell_next;
            cell_reg.g_output <= s2_go_reg;
        end
    end

    assign cell_stage = cell_reg;

    `ASSERT_IMPL(a_no_adjacent_same_pos, gate.valid && $past(gate.valid && en),
                 gate.pos != $past(gate.pos), "adjacent items share an entry")
    `ASSERT_IMPL(a_write_only_valid, cell_reg.valid && $past(en), $past(s2_valid_reg), "cell stage valid without source")
    `ASSERT_IMPL(a_first_prev_zero, gate.valid && gate.first, prev == '0, "first step carries a previous cell")

endmodule

FILE: src/lcu_hidden_out.sv
// Hidden path: tanh of the cell, output-gate product, rounding, output register.
`include "assert_macros.svh"
module lcu_hidden_out import lcu_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cell_t cell_stage,
    output logic  out_valid,
    output q_t    hidden_out,
    output q_t    cell_out
);

    logic               s4_valid_reg;
    q_t                 s4_t_reg;
    q_t                 s4_go_reg;
    q_t                 s4_cell_reg;
    logic               s5_valid_reg;
    logic signed [31:0] s5_prod_reg;
    q_t                 s5_cell_reg;
    logic               out_valid_reg;
    q_t                 hidden_reg;
    q_t                 cell_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s4_valid_reg  <= cell_stage.valid;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
        if (en) begin
            s4_t_reg     <= pwl_tanh(cell_stage.value);
            s4_go_reg    <= cell_stage.g_output;
            s4_cell_reg  <= cell_stage.value;
            s5_prod_reg  <= 32'(s4_t_reg) * 32'(s4_go_reg);
            s5_cell_reg  <= s4_cell_reg;
            hidden_reg   <= rescale(PROD_W'(s5_prod_reg));
            cell_out_reg <= s5_cell_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hidden_out = hidden_reg;
    assign cell_out   = cell_out_reg;

    `ASSERT_IMPL(a_out_from_s5, $rose(out_valid_reg), $past(s5_valid_reg), "output valid without source")

endmodule
